// File: rtl/ttb_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// ttb_pkg
// Shared types and fixed-point helpers for the tangent frame unit.
// ----------------------------------------------------------------------------
package ttb_pkg;

	localparam int IDX_W = 16;
	localparam int VAL_W = 32;
	// vertex storage size, a power of two
	localparam int MAX_VERTICES = 65536;

	typedef struct packed {
		logic [IDX_W-1:0]        vertex_index;
		logic signed [VAL_W-1:0] pos_x;
		logic signed [VAL_W-1:0] pos_y;
		logic signed [VAL_W-1:0] pos_z;
		logic signed [VAL_W-1:0] tex_u;
		logic signed [VAL_W-1:0] tex_v;
	} corner_t;

	typedef struct packed {
		logic [IDX_W-1:0]        out_index;
		logic signed [VAL_W-1:0] tangent_x;
		logic signed [VAL_W-1:0] tangent_y;
		logic signed [VAL_W-1:0] tangent_z;
		logic signed [VAL_W-1:0] bitan_x;
		logic signed [VAL_W-1:0] bitan_y;
		logic signed [VAL_W-1:0] bitan_z;
		logic                    degenerate;
		logic                    last_of_triangle;
	} frame_t;

	// triangle job handed from front to back
	typedef struct packed {
		logic signed [VAL_W-1:0] e1x, e1y, e1z, e2x, e2y, e2z;
		logic signed [VAL_W-1:0] du1, dv1, du2, dv2;
		logic [IDX_W-1:0]        i0, i1, i2;
	} tri_job_t;

	function automatic logic signed [VAL_W-1:0] sat33(input logic signed [VAL_W:0] v);
		if (v > 33'sd2147483647)
			return 32'sh7fffffff;
		else if (v < -33'sd2147483648)
			return 32'sh80000000;
		else
			return v[VAL_W-1:0];
	endfunction

	function automatic logic signed [VAL_W-1:0] qsub(input logic signed [VAL_W-1:0] a,
		input logic signed [VAL_W-1:0] b);
		return sat33({a[VAL_W-1], a} - {b[VAL_W-1], b});
	endfunction

	function automatic logic signed [VAL_W-1:0] qadd(input logic signed [VAL_W-1:0] a,
		input logic signed [VAL_W-1:0] b);
		return sat33({a[VAL_W-1], a} + {b[VAL_W-1], b});
	endfunction

endpackage
`default_nettype wire

// File: rtl/ttb_qmul.sv
`default_nettype none
// ----------------------------------------------------------------------------
// ttb_qmul
// Registered fixed-point multiply: floor shift, saturate to 32 bits.
// ----------------------------------------------------------------------------
module ttb_qmul
	import ttb_pkg::*;
#(
	parameter int FRAC_BITS = 16
) (
	input  wire logic                    clk,
	input  wire logic signed [VAL_W-1:0] a,
	input  wire logic signed [VAL_W-1:0] b,
	output logic signed [VAL_W-1:0]      p
);
	logic signed [2*VAL_W-1:0] prod_s1;
	logic signed [2*VAL_W-1:0] shr;

	always_ff @(posedge clk) begin
		prod_s1 <= a * b;
	end

	always_comb begin
		shr = prod_s1 >>> FRAC_BITS;   // arithmetic shift rounds toward minus infinity
		if (shr > 64'sd2147483647)
			p = 32'sh7fffffff;
		else if (shr < -64'sd2147483648)
			p = 32'sh80000000;
		else
			p = shr[VAL_W-1:0];
	end
endmodule
`default_nettype wire

// File: rtl/ttb_recip.sv
`default_nettype none
// ----------------------------------------------------------------------------
// ttb_recip
// Restoring divider: 2^(2*FRAC_BITS) / det, toward zero, saturated.
// ----------------------------------------------------------------------------
module ttb_recip
	import ttb_pkg::*;
#(
	parameter int FRAC_BITS = 16
) (
	input  wire logic                    clk,
	input  wire logic                    arst_n,
	input  wire logic                    go,
	input  wire logic signed [VAL_W-1:0] det,
	output logic                         done,
	output logic signed [VAL_W-1:0]      f
);
	localparam int NW = 2 * FRAC_BITS + 1;   // dividend width
	localparam int CW = $clog2(NW + 1);

	logic [NW-1:0]    quo_q;
	logic [VAL_W:0]   rem_q;
	logic [VAL_W-1:0] dmag_q;
	logic             neg_q;
	logic [CW-1:0]    cnt_q;
	logic             run_q;
	logic [VAL_W+1:0] trial;
	logic [VAL_W:0]   rem_sh;

	assign rem_sh = {rem_q[VAL_W-1:0], quo_q[NW-1]};
	assign trial  = {1'b0, rem_sh} - {2'b0, dmag_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q <= 1'b0;
			cnt_q <= '0;
			done  <= 1'b0;
		end else begin
			done <= run_q && !go && (cnt_q == CW'(1));
			if (go) begin
				run_q <= 1'b1;
				cnt_q <= CW'(NW);
			end else if (run_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == CW'(1)) run_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (go) begin
			quo_q  <= NW'(1) << (2 * FRAC_BITS);
			rem_q  <= '0;
			neg_q  <= det[VAL_W-1];
			dmag_q <= det[VAL_W-1] ? VAL_W'(-det) : VAL_W'(det);
		end else if (run_q) begin
			if (!trial[VAL_W+1]) begin
				rem_q <= trial[VAL_W:0];
				quo_q <= {quo_q[NW-2:0], 1'b1};
			end else begin
				rem_q <= rem_sh;
				quo_q <= {quo_q[NW-2:0], 1'b0};
			end
		end
	end

	// magnitude of -2^31 handled: dmag is unsigned 32 bits
	always_comb begin
		if (!neg_q)
			f = (quo_q > NW'(32'h7fffffff)) ? 32'sh7fffffff : VAL_W'(quo_q);
		else
			f = (quo_q > NW'(33'h80000000)) ? 32'sh80000000 : VAL_W'(-quo_q);
	end
endmodule
`default_nettype wire

// File: rtl/ttb_front.sv
`default_nettype none
// ----------------------------------------------------------------------------
// ttb_front
// Collects three corners and forms edges and uv deltas per triangle.
// ----------------------------------------------------------------------------
module ttb_front
	import ttb_pkg::*;
(
	input  wire logic     clk,
	input  wire logic     arst_n,
	input  wire logic     take,
	input  wire corner_t  corner,
	output logic          job_valid,
	output tri_job_t      job
);
	localparam int MW = (MAX_VERTICES >= 65536) ? IDX_W : $clog2(MAX_VERTICES);

	logic [1:0] cnt_q;
	corner_t    c0_q, c1_q;

	function automatic logic [IDX_W-1:0] wrap(input logic [IDX_W-1:0] i);
		return IDX_W'(i[MW-1:0]);
	endfunction

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q     <= '0;
			job_valid <= 1'b0;
		end else begin
			job_valid <= take && (cnt_q == 2'd2);
			if (take) cnt_q <= (cnt_q == 2'd2) ? 2'd0 : cnt_q + 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (take && cnt_q == 2'd0) c0_q <= corner;
		if (take && cnt_q == 2'd1) c1_q <= corner;
		if (take && cnt_q == 2'd2) begin
			job.e1x <= qsub(c1_q.pos_x, c0_q.pos_x);
			job.e1y <= qsub(c1_q.pos_y, c0_q.pos_y);
			job.e1z <= qsub(c1_q.pos_z, c0_q.pos_z);
			job.e2x <= qsub(corner.pos_x, c0_q.pos_x);
			job.e2y <= qsub(corner.pos_y, c0_q.pos_y);
			job.e2z <= qsub(corner.pos_z, c0_q.pos_z);
			job.du1 <= qsub(c1_q.tex_u, c0_q.tex_u);
			job.dv1 <= qsub(c1_q.tex_v, c0_q.tex_v);
			job.du2 <= qsub(corner.tex_u, c0_q.tex_u);
			job.dv2 <= qsub(corner.tex_v, c0_q.tex_v);
			job.i0  <= wrap(c0_q.vertex_index);
			job.i1  <= wrap(c1_q.vertex_index);
			job.i2  <= wrap(corner.vertex_index);
		end
	end
endmodule
`default_nettype wire

// File: rtl/ttb_back.sv
`default_nettype none
// ----------------------------------------------------------------------------
// ttb_back
// Sequencer: determinant, reciprocal, vector terms, scaling, three words out.
// One shared registered multiplier does all products.
// ----------------------------------------------------------------------------
module ttb_back
	import ttb_pkg::*;
#(
	parameter int FRAC_BITS = 16
) (
	input  wire logic      clk,
	input  wire logic      arst_n,
	input  wire logic      job_valid,
	input  wire tri_job_t  job,
	output logic           idle,
	output logic           res_valid,
	output frame_t         res
);
	localparam logic [2:0] ST_IDLE = 3'd0;
	localparam logic [2:0] ST_DET  = 3'd1;
	localparam logic [2:0] ST_DIV  = 3'd2;
	localparam logic [2:0] ST_TERM = 3'd3;
	localparam logic [2:0] ST_SCL  = 3'd4;
	localparam logic [2:0] ST_OUT  = 3'd5;

	logic [2:0]              st_q;
	logic [4:0]              step_q;   // product issue index, one per cycle
	tri_job_t                j_q;
	logic signed [VAL_W-1:0] ma, mb, mp;
	logic signed [VAL_W-1:0] prev_q;  // first product of a pair
	logic signed [VAL_W-1:0] det_c, f_q;
	logic signed [VAL_W-1:0] term_q [6];
	logic signed [VAL_W-1:0] vec_q [6];
	logic                    degen_q;
	logic [1:0]              ocnt_q;
	logic                    rgo, rdone;
	logic signed [VAL_W-1:0] rf;

	ttb_qmul #(.FRAC_BITS(FRAC_BITS)) u_mul (.clk(clk), .a(ma), .b(mb), .p(mp));
	ttb_recip #(.FRAC_BITS(FRAC_BITS)) u_rcp (
		.clk(clk), .arst_n(arst_n), .go(rgo), .det(det_c), .done(rdone), .f(rf));

	function automatic logic signed [VAL_W-1:0] edge_sel(input tri_job_t j,
		input logic second, input logic [1:0] c);
		logic signed [VAL_W-1:0] r;
		r = '0;
		unique case (c)
			2'd0:    r = second ? j.e2x : j.e1x;
			2'd1:    r = second ? j.e2y : j.e1y;
			default: r = second ? j.e2z : j.e1z;
		endcase
		return r;
	endfunction

	// product schedule; a product issued at one step is visible at the next step
	always_comb begin
		ma = '0;
		mb = '0;
		unique case (st_q)
			ST_DET: begin
				ma = step_q[0] ? j_q.du2 : j_q.du1;
				mb = step_q[0] ? j_q.dv1 : j_q.dv2;
			end
			ST_TERM: begin
				// step = 4*c + k; k0 dv2*e1, k1 dv1*e2, k2 du1*e2, k3 du2*e1
				unique case (step_q[1:0])
					2'd0: begin ma = j_q.dv2; mb = edge_sel(j_q, 1'b0, step_q[3:2]); end
					2'd1: begin ma = j_q.dv1; mb = edge_sel(j_q, 1'b1, step_q[3:2]); end
					2'd2: begin ma = j_q.du1; mb = edge_sel(j_q, 1'b1, step_q[3:2]); end
					default: begin ma = j_q.du2; mb = edge_sel(j_q, 1'b0, step_q[3:2]); end
				endcase
			end
			ST_SCL: begin
				ma = f_q;
				mb = term_q[(step_q < 5'd6) ? step_q[2:0] : 3'd0];
			end
			default: ;
		endcase
	end

	// determinant is valid in the last DET step; the divider loads it there
	assign det_c = qsub(prev_q, mp);
	assign rgo   = (st_q == ST_DET) && (step_q == 5'd2) && (det_c != '0);
	assign idle  = (st_q == ST_IDLE);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q      <= ST_IDLE;
			step_q    <= '0;
			ocnt_q    <= '0;
			res_valid <= 1'b0;
		end else begin
			res_valid <= (st_q == ST_OUT);
			unique case (st_q)
				ST_IDLE: if (job_valid) begin
					st_q   <= ST_DET;
					step_q <= '0;
				end
				ST_DET: begin
					if (step_q == 5'd2) begin
						step_q <= '0;
						if (det_c == '0) begin
							st_q   <= ST_OUT;
							ocnt_q <= '0;
						end else begin
							st_q <= ST_DIV;
						end
					end else begin
						step_q <= step_q + 1'b1;
					end
				end
				ST_DIV: if (rdone) begin
					st_q   <= ST_TERM;
					step_q <= '0;
				end
				ST_TERM: begin
					if (step_q == 5'd12) begin
						st_q   <= ST_SCL;
						step_q <= '0;
					end else begin
						step_q <= step_q + 1'b1;
					end
				end
				ST_SCL: begin
					step_q <= step_q + 1'b1;
					if (step_q == 5'd6) begin
						st_q   <= ST_OUT;
						ocnt_q <= '0;
					end
				end
				ST_OUT: begin
					ocnt_q <= ocnt_q + 1'b1;
					if (ocnt_q == 2'd2) st_q <= ST_IDLE;
				end
				default: st_q <= ST_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (st_q == ST_IDLE && job_valid) j_q <= job;
		if (st_q == ST_DET && step_q == 5'd1) prev_q <= mp;
		if (st_q == ST_DET && step_q == 5'd2) begin
			degen_q <= (det_c == '0);
			for (int i = 0; i < 6; i++) vec_q[i] <= '0;
		end
		if (st_q == ST_DIV && rdone) f_q <= rf;
		if (st_q == ST_TERM && step_q != 5'd0) begin
			// results of step-1
			unique case (step_q[1:0])
				2'd1, 2'd3: prev_q <= mp;
				2'd2: term_q[3'((step_q - 5'd1) >> 2)] <= qsub(prev_q, mp);
				default: term_q[3'(((step_q - 5'd1) >> 2) + 5'd3)] <= qsub(prev_q, mp);
			endcase
		end
		if (st_q == ST_SCL && step_q != 5'd0) vec_q[3'(step_q - 5'd1)] <= mp;
		if (st_q == ST_OUT) begin
			res.out_index <= (ocnt_q == 2'd0) ? j_q.i0 :
				(ocnt_q == 2'd1) ? j_q.i1 : j_q.i2;
			res.tangent_x        <= vec_q[0];
			res.tangent_y        <= vec_q[1];
			res.tangent_z        <= vec_q[2];
			res.bitan_x          <= vec_q[3];
			res.bitan_y          <= vec_q[4];
			res.bitan_z          <= vec_q[5];
			res.degenerate       <= degen_q;
			res.last_of_triangle <= (ocnt_q == 2'd2);
		end
	end
endmodule
`default_nettype wire

// File: rtl/triangle_tangent_bitangent.sv
`default_nettype none
// ----------------------------------------------------------------------------
// triangle_tangent_bitangent
// Per-triangle tangent and bitangent from three corners, Q16.16.
// ----------------------------------------------------------------------------
// Usage: drive corner with start high; a word is taken when start is high and
// busy is low. The first two corners are only stored. The third forms edges and
// uv deltas in the front part and queues one triangle job (one slot) for the
// back part, which runs a 33-step restoring divider for the reciprocal of the
// uv determinant and one shared registered multiplier for the 2 + 12 + 6
// products. The back part then emits three result words back to back, each
// marked by valid for one cycle; the third has last_of_triangle.
// A zero determinant skips the divider and gives zero vectors, degenerate=1.
// The back part takes a new job only when idle, and its throughput is set by
// the divider plus the multiplier schedule; while it works, the front part can
// collect the next triangle's corners. busy is high while a triangle job
// waits in the queue slot.
// Reset clears the corner count, the queue and the sequencer. The receiver
// cannot stall results.
// ----------------------------------------------------------------------------
module triangle_tangent_bitangent
	import ttb_pkg::*;
#(
	parameter int FRAC_BITS = 16
) (
	input  wire logic    clk,
	input  wire logic    arst_n,
	input  wire logic    start,
	output logic         busy,
	input  wire corner_t corner,
	output logic         valid,
	output frame_t       result
);
	logic     take;
	logic     fj_valid;
	tri_job_t fj;
	logic     qv_q;
	tri_job_t q_q;
	logic     back_idle;

	assign busy = qv_q;
	assign take = start & ~busy;

	ttb_front u_front (
		.clk(clk), .arst_n(arst_n), .take(take), .corner(corner),
		.job_valid(fj_valid), .job(fj));

	ttb_back #(.FRAC_BITS(FRAC_BITS)) u_back (
		.clk(clk), .arst_n(arst_n), .job_valid(qv_q), .job(q_q),
		.idle(back_idle), .res_valid(valid), .res(result));

	// one-slot job queue; front stalls only while it is full
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			qv_q <= 1'b0;
		end else begin
			if (fj_valid) qv_q <= 1'b1;
			else if (qv_q && back_idle) qv_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (fj_valid) q_q <= fj;
	end

	ast_no_res_idle: assert property (@(posedge clk) disable iff (!arst_n)
		valid |-> !back_idle || $past(!back_idle)) else $error("result while idle");
	ast_busy_q: assert property (@(posedge clk) disable iff (!arst_n)
		qv_q |-> busy) else $error("queue full but not busy");
	ast_job_free: assert property (@(posedge clk) disable iff (!arst_n)
		fj_valid |-> !$past(qv_q && !back_idle)) else $error("queue overrun");
endmodule
`default_nettype wire

// File: bench/triangle_tangent_bitangent_test.sv
`timescale 1ns / 100ps
`default_nettype none
// ----------------------------------------------------------------------------
// triangle_tangent_bitangent_test
// Drives triangle corners into the tangent frame unit with random start gaps.
// A behavioral predictor computes the three frames per triangle; every result
// word is checked field by field against the oldest expected frame.
// ----------------------------------------------------------------------------
module triangle_tangent_bitangent_test;
	import ttb_pkg::*;

	localparam int FRAC = 16;
	localparam longint SMAX = 64'sd2147483647;
	localparam longint SMIN = -64'sd2147483648;

	logic    clk = 1'b0;
	logic    arst_n = 1'b0;
	logic    start = 1'b0;
	logic    busy;
	corner_t corner = '0;
	logic    valid;
	frame_t  result;

	triangle_tangent_bitangent u_dut (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy),
		.corner(corner), .valid(valid), .result(result)
	);

	always #1 clk = ~clk;

	initial begin
		#20_000_000;
		$display("triangle_tangent_bitangent_test: FAIL");
		$finish;
	end

	// predictor state
	int      corners_held;
	corner_t held [2];
	frame_t  frame_q [$];
	int      errors = 0;
	int      frames_seen = 0;
	int      degen_seen = 0;
	int      sent = 0;
	int      idle_pct = 0;

	function automatic longint clamp32(input longint v);
		if (v > SMAX) return SMAX;
		if (v < SMIN) return SMIN;
		return v;
	endfunction

	// >>> on longint is arithmetic, i.e. floor
	function automatic longint fxmul(input longint a, input longint b);
		longint p;
		p = a * b;
		return clamp32(p >>> FRAC);
	endfunction

	function automatic longint fxsub(input longint a, input longint b);
		return clamp32(a - b);
	endfunction

	task automatic predict_corner(input corner_t c);
		longint e1 [3], e2 [3], p0 [3], p1 [3], p2 [3];
		longint du1, dv1, du2, dv2, det, f;
		logic [31:0] tg [3], bt [3];
		frame_t fr;
		if (corners_held < 2) begin
			held[corners_held] = c;
			corners_held++;
			return;
		end
		corners_held = 0;
		p0 = '{held[0].pos_x, held[0].pos_y, held[0].pos_z};
		p1 = '{held[1].pos_x, held[1].pos_y, held[1].pos_z};
		p2 = '{c.pos_x, c.pos_y, c.pos_z};
		for (int k = 0; k < 3; k++) begin
			e1[k] = fxsub(p1[k], p0[k]);
			e2[k] = fxsub(p2[k], p0[k]);
		end
		du1 = fxsub(held[1].tex_u, held[0].tex_u);
		dv1 = fxsub(held[1].tex_v, held[0].tex_v);
		du2 = fxsub(c.tex_u, held[0].tex_u);
		dv2 = fxsub(c.tex_v, held[0].tex_v);
		det = fxsub(fxmul(du1, dv2), fxmul(du2, dv1));
		for (int k = 0; k < 3; k++) begin
			tg[k] = '0;
			bt[k] = '0;
		end
		if (det != 0) begin
			f = clamp32((64'sd1 << (2 * FRAC)) / det);
			for (int k = 0; k < 3; k++) begin
				tg[k] = 32'(fxmul(f, fxsub(fxmul(dv2, e1[k]), fxmul(dv1, e2[k]))));
				bt[k] = 32'(fxmul(f, fxsub(fxmul(du1, e2[k]), fxmul(du2, e1[k]))));
			end
		end
		for (int j = 0; j < 3; j++) begin
			fr.out_index = (j == 0) ? held[0].vertex_index :
				(j == 1) ? held[1].vertex_index : c.vertex_index;
			fr.tangent_x = tg[0];
			fr.tangent_y = tg[1];
			fr.tangent_z = tg[2];
			fr.bitan_x = bt[0];
			fr.bitan_y = bt[1];
			fr.bitan_z = bt[2];
			fr.degenerate = (det == 0);
			fr.last_of_triangle = (j == 2);
			frame_q.insert(frame_q.size(), fr);
		end
	endtask

	// result checker
	always @(posedge clk) begin
		if (arst_n && valid) begin
			frame_t want;
			if (frame_q.size() == 0) begin
				$display("%0t: unexpected word %p", $time, result);
				errors++;
			end else begin
				want = frame_q.pop_front();
				frames_seen++;
				if (result.degenerate) degen_seen++;
				if (result.out_index !== want.out_index)
					$display("%0t: out_index exp %h got %h", $time, want.out_index,
						result.out_index);
				if (result.tangent_x !== want.tangent_x)
					$display("%0t: tangent_x exp %h got %h", $time, want.tangent_x,
						result.tangent_x);
				if (result.tangent_y !== want.tangent_y)
					$display("%0t: tangent_y exp %h got %h", $time, want.tangent_y,
						result.tangent_y);
				if (result.tangent_z !== want.tangent_z)
					$display("%0t: tangent_z exp %h got %h", $time, want.tangent_z,
						result.tangent_z);
				if (result.bitan_x !== want.bitan_x)
					$display("%0t: bitan_x exp %h got %h", $time, want.bitan_x,
						result.bitan_x);
				if (result.bitan_y !== want.bitan_y)
					$display("%0t: bitan_y exp %h got %h", $time, want.bitan_y,
						result.bitan_y);
				if (result.bitan_z !== want.bitan_z)
					$display("%0t: bitan_z exp %h got %h", $time, want.bitan_z,
						result.bitan_z);
				if (result.degenerate !== want.degenerate)
					$display("%0t: degenerate exp %b got %b", $time, want.degenerate,
						result.degenerate);
				if (result.last_of_triangle !== want.last_of_triangle)
					$display("%0t: last_of_triangle exp %b got %b", $time,
						want.last_of_triangle, result.last_of_triangle);
				if (result !== want) errors++;
			end
		end
	end

	// hold start for one accepted word; idle gaps per idle_pct
	task automatic send_corner(input corner_t c);
		while (idle_pct != 0 && $urandom_range(99) < idle_pct) begin
			start <= 1'b0;
			@(posedge clk);
		end
		start <= 1'b1;
		corner <= c;
		// busy is registered: look at it mid cycle, the word goes at the next edge
		@(negedge clk);
		while (busy) @(negedge clk);
		@(posedge clk);
		predict_corner(c);
		sent++;
	endtask

	function automatic logic [31:0] rand_val();
		case ($urandom_range(5))
			0: return 32'h7fffffff;
			1: return 32'h80000000;
			2: return $urandom_range(8) << 16;
			3: return $urandom_range(255) - 128;
			default: return $urandom;
		endcase
	endfunction

	function automatic corner_t rand_corner();
		corner_t c;
		c.vertex_index = 16'($urandom);
		c.pos_x = rand_val();
		c.pos_y = rand_val();
		c.pos_z = rand_val();
		c.tex_u = rand_val();
		c.tex_v = rand_val();
		return c;
	endfunction

	task automatic drain();
		start <= 1'b0;
		while (frame_q.size() != 0) @(posedge clk);
		repeat (80) @(posedge clk);
	endtask

	// directed corners, three per triangle
	localparam int NDIR = 21;
	corner_t dir_tab [NDIR];
	frame_t  zero_frame;

	initial begin
		corner_t c;
		// unit uv square, simple triangle
		dir_tab[0]  = '{16'h0000, 32'h0, 32'h0, 32'h0, 32'h0, 32'h0};
		dir_tab[1]  = '{16'h0001, 32'h10000, 32'h0, 32'h0, 32'h10000, 32'h0};
		dir_tab[2]  = '{16'hffff, 32'h0, 32'h10000, 32'h0, 32'h0, 32'h10000};
		// identical uv: degenerate
		dir_tab[3]  = '{16'h1234, 32'h7fffffff, 32'h1, 32'h2, 32'h5, 32'h5};
		dir_tab[4]  = '{16'h5678, 32'h80000000, 32'h3, 32'h4, 32'h5, 32'h5};
		dir_tab[5]  = '{16'h9abc, 32'h0, 32'h7fffffff, 32'h80000000, 32'h5, 32'h5};
		// extreme positions and uv: saturating differences
		dir_tab[6]  = '{16'h0000, 32'h80000000, 32'h80000000, 32'h80000000,
			32'h80000000, 32'h80000000};
		dir_tab[7]  = '{16'hffff, 32'h7fffffff, 32'h7fffffff, 32'h7fffffff,
			32'h7fffffff, 32'h80000000};
		dir_tab[8]  = '{16'h8000, 32'h7fffffff, 32'h80000000, 32'h7fffffff,
			32'h80000000, 32'h7fffffff};
		// tiny determinant: reciprocal saturates
		dir_tab[9]  = '{16'h0010, 32'h0, 32'h0, 32'h0, 32'h0, 32'h0};
		dir_tab[10] = '{16'h0011, 32'h10000, 32'h20000, 32'h30000, 32'h100, 32'h0};
		dir_tab[11] = '{16'h0012, 32'hfffe0000, 32'h10000, 32'h0, 32'h0, 32'h100};
		// negative determinant
		dir_tab[12] = '{16'h0020, 32'h0, 32'h0, 32'h0, 32'h0, 32'h0};
		dir_tab[13] = '{16'h0021, 32'h10000, 32'h0, 32'h0, 32'h0, 32'h10000};
		dir_tab[14] = '{16'h0022, 32'h0, 32'h10000, 32'h0, 32'h10000, 32'h0};
		// products that underflow to zero det (floor)
		dir_tab[15] = '{16'h0030, 32'h1, 32'h2, 32'h3, 32'h0, 32'h0};
		dir_tab[16] = '{16'h0031, 32'h4, 32'h5, 32'h6, 32'h1, 32'h0};
		dir_tab[17] = '{16'h0032, 32'h7, 32'h8, 32'h9, 32'h0, 32'h1};
		// all ones in every field, then alternating bit patterns
		dir_tab[18] = '{16'hffff, 32'hffffffff, 32'hffffffff, 32'hffffffff,
			32'hffffffff, 32'hffffffff};
		dir_tab[19] = '{16'h5555, 32'h55555555, 32'haaaaaaaa, 32'h55555555,
			32'haaaaaaaa, 32'h55555555};
		dir_tab[20] = '{16'haaaa, 32'haaaaaaaa, 32'h55555555, 32'haaaaaaaa,
			32'h55555555, 32'haaaaaaaa};

		corners_held = 0;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		for (int i = 0; i < NDIR; i++) begin
			send_corner(dir_tab[i]);
			// degenerate triangle: known zero frames, typed in
			if (i == 5) begin
				zero_frame = '0;
				zero_frame.degenerate = 1'b1;
				for (int j = 0; j < 3; j++) begin
					zero_frame.out_index = dir_tab[3 + j].vertex_index;
					zero_frame.last_of_triangle = (j == 2);
					if (frame_q[frame_q.size() - 3 + j] !== zero_frame) begin
						$display("%0t: degenerate row exp %p got %p", $time,
							zero_frame, frame_q[frame_q.size() - 3 + j]);
						errors++;
					end
				end
			end
		end
		drain();

		// random phases: no idling, sender idle 50%, 12%, then none
		for (int ph = 0; ph < 4; ph++) begin
			idle_pct = (ph == 1) ? 50 : (ph == 2) ? 12 : 0;
			for (int t = 0; t < 57; t++) begin
				c = rand_corner();
				// some degenerate triangles: uv copied from first corner
				if (corners_held == 2 && $urandom_range(7) == 0) begin
					c.tex_u = held[0].tex_u;
					c.tex_v = held[0].tex_v;
				end
				send_corner(c);
			end
			// pause until every expected word has come
			drain();
		end

		while (frame_q.size() != 0) @(posedge clk);
		repeat (100) @(posedge clk);
		$display("Covered %0d corners, %0d frames checked, %0d degenerate.",
			sent, frames_seen, degen_seen);
		if (errors == 0)
			$display("triangle_tangent_bitangent_test: PASS");
		else
			$display("triangle_tangent_bitangent_test: FAIL");
		$finish;
	end

endmodule
`default_nettype wire

// File: files.f
rtl/ttb_pkg.sv
rtl/ttb_qmul.sv
rtl/ttb_recip.sv
rtl/ttb_front.sv
rtl/ttb_back.sv
rtl/triangle_tangent_bitangent.sv
bench/triangle_tangent_bitangent_test.sv
